// File: hdl/nus_pkg.sv
// Shared constants and register indexes for the nearest-neighbour upsampling scatter block.
package nus_pkg;

    localparam int DEF_MAX_PLANE_DIM = 1024;
    localparam int DEF_MAX_DEPTH     = 64;
    localparam int DEF_MAX_CHANNELS  = 1024;
    localparam int DEF_MAX_SCALE     = 4;

    localparam int OFF_W     = 42;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_DEPTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE     = 3'd7;

    localparam logic FILL_REPLICATE = 1'b0;

endpackage

// File: hdl/nus_mul.sv
// Shared multiplier with a registered, truncated product.
module nus_mul #(
    parameter int A_W = nus_pkg::OFF_W,
    parameter int B_W = 16,
    parameter int P_W = nus_pkg::OFF_W
) (
    input  logic           i_clk,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic [P_W-1:0] o_prod
);
    logic [A_W+B_W-1:0] w_full;
    logic [P_W-1:0]     r_prod;

    assign w_full = (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);

    // Offsets wrap modulo the output width, so the high product bits are dropped.
    always_ff @(posedge i_clk) begin
        r_prod <= w_full[P_W-1:0];
    end

    assign o_prod = r_prod;
endmodule

// File: hdl/nus_pos.sv
// Raster position counters for channel, z, y and x of the current input element.
module nus_pos #(
    parameter int MAX_PLANE_DIM = nus_pkg::DEF_MAX_PLANE_DIM,
    parameter int MAX_DEPTH     = nus_pkg::DEF_MAX_DEPTH,
    parameter int MAX_CHANNELS  = nus_pkg::DEF_MAX_CHANNELS,
    localparam int DIM_W = $clog2(MAX_PLANE_DIM + 1),
    localparam int DD_W  = $clog2(MAX_DEPTH + 1),
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1),
    localparam int PX_W  = $clog2(MAX_PLANE_DIM),
    localparam int PZ_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
    localparam int PC_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic [DD_W-1:0]  i_depth,
    input  logic [CH_W-1:0]  i_channels,
    output logic [PX_W-1:0]  o_pos_x,
    output logic [PX_W-1:0]  o_pos_y,
    output logic [PZ_W-1:0]  o_pos_z,
    output logic [PC_W-1:0]  o_pos_c
);
    localparam int XC_W = DIM_W + 1;
    localparam int ZC_W = ((DD_W > PZ_W) ? DD_W : PZ_W) + 1;
    localparam int CC_W = ((CH_W > PC_W) ? CH_W : PC_W) + 1;

    logic [PX_W-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [PZ_W-1:0] r_pos_z, n_pos_z;
    logic [PC_W-1:0] r_pos_c, n_pos_c;
    logic            w_x_more, w_y_more, w_z_more, w_c_more;

    assign w_x_more = (XC_W'(r_pos_x) + XC_W'(1)) < XC_W'(i_width);
    assign w_y_more = (XC_W'(r_pos_y) + XC_W'(1)) < XC_W'(i_height);
    assign w_z_more = (ZC_W'(r_pos_z) + ZC_W'(1)) < ZC_W'(i_depth);
    assign w_c_more = (CC_W'(r_pos_c) + CC_W'(1)) < CC_W'(i_channels);

    // A position left beyond a newly shrunk size is used once, then wraps to zero.
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_pos_c = r_pos_c;
        if (i_advance) begin
            priority if (w_x_more) begin
                n_pos_x = r_pos_x + PX_W'(1);
            end else if (w_y_more) begin
                n_pos_x = '0;
                n_pos_y = r_pos_y + PX_W'(1);
            end else if (w_z_more) begin
                n_pos_x = '0;
                n_pos_y = '0;
                n_pos_z = r_pos_z + PZ_W'(1);
            end else if (w_c_more) begin
                n_pos_x = '0;
                n_pos_y = '0;
                n_pos_z = '0;
                n_pos_c = r_pos_c + PC_W'(1);
            end else begin
                n_pos_x = '0;
                n_pos_y = '0;
                n_pos_z = '0;
                n_pos_c = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_pos_c <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_pos_c <= n_pos_c;
        end
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;
    assign o_pos_c = r_pos_c;
endmodule

// File: hdl/nearest_upsample_scatter_core.sv
// Top level of the 3-D nearest-neighbour upsampling scatter: sequencer, write walker and config.
// Each accepted input beat is one element in channel, z, y, x raster order; the block answers
// with scale_z*scale_y*scale_x output beats (z, then y, then x) carrying the offset within the
// upsampled sample, the value (or zero away from the corner in zero-insert mode) and a flag on
// the final write of the block. After an input beat is accepted, a sequencer works through its
// setup steps one after another on one shared multiplier, working out the output sizes, the
// plane stride and the block's base offset, then emits one write per cycle while the output
// side takes them. The user must write configuration only while the block is idle; the block
// itself does not enforce this.
module nearest_upsample_scatter_core #(
    parameter int MAX_PLANE_DIM = nus_pkg::DEF_MAX_PLANE_DIM,
    parameter int MAX_DEPTH     = nus_pkg::DEF_MAX_DEPTH,
    parameter int MAX_CHANNELS  = nus_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_SCALE     = nus_pkg::DEF_MAX_SCALE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nus_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nus_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nus_pkg::VAL_W-1:0]     i_sample_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nus_pkg::OFF_W-1:0]     o_out_offset,
    output logic [nus_pkg::VAL_W-1:0]     o_out_value,
    output logic                          o_block_last
);
    import nus_pkg::*;

    localparam int DIM_W = $clog2(MAX_PLANE_DIM + 1);
    localparam int DD_W  = $clog2(MAX_DEPTH + 1);
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SC_W  = $clog2(MAX_SCALE + 1);
    localparam int PX_W  = $clog2(MAX_PLANE_DIM);
    localparam int PZ_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PC_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int OX_W  = $clog2(MAX_PLANE_DIM * MAX_SCALE + 1);
    localparam int OZ_W  = $clog2(MAX_DEPTH * MAX_SCALE + 1);
    localparam int MB_W  = (OX_W > OZ_W) ? OX_W : OZ_W;

    localparam logic [3:0] ST_OUT_X  = 4'd0;
    localparam logic [3:0] ST_OUT_Y  = 4'd1;
    localparam logic [3:0] ST_OUT_Z  = 4'd2;
    localparam logic [3:0] ST_STRIDE = 4'd3;
    localparam logic [3:0] ST_Z0     = 4'd4;
    localparam logic [3:0] ST_Y0     = 4'd5;
    localparam logic [3:0] ST_X0     = 4'd6;
    localparam logic [3:0] ST_CH     = 4'd7;
    localparam logic [3:0] ST_ADD_Z  = 4'd8;
    localparam logic [3:0] ST_MUL_Y  = 4'd9;
    localparam logic [3:0] ST_ADD_Y  = 4'd10;
    localparam logic [3:0] ST_MUL_X  = 4'd11;
    localparam logic [3:0] ST_BASE   = 4'd12;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    function automatic logic [15:0] f_eff(input logic [15:0] v, input logic [15:0] mx);
        if (v == 16'd0) begin
            return 16'd1;
        end else if (v > mx) begin
            return mx;
        end
        return v;
    endfunction

    // Configuration registers.
    logic [10:0] r_in_width, r_in_height, r_channel_count;
    logic [6:0]  r_in_depth;
    logic [2:0]  r_scale_x, r_scale_y, r_scale_z;
    logic        r_fill_mode;

    logic [DIM_W-1:0] w_w, w_h;
    logic [DD_W-1:0]  w_d;
    logic [CH_W-1:0]  w_c;
    logic [SC_W-1:0]  w_sx, w_sy, w_sz;

    logic [PX_W-1:0] w_pos_x, w_pos_y;
    logic [PZ_W-1:0] w_pos_z;
    logic [PC_W-1:0] w_pos_c;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;

    logic [VAL_W-1:0] r_value;
    logic [OX_W-1:0]  r_out_x, r_out_y, r_y0, r_x0;
    logic [OZ_W-1:0]  r_out_z, r_z0;
    logic [OFF_W-1:0] r_stride, r_acc, r_off, r_row, r_plane;
    logic [SC_W-1:0]  r_ox, r_oy, r_oz;

    logic [OFF_W-1:0] w_mul_a, w_prod;
    logic [MB_W-1:0]  w_mul_b;

    logic             r_out_valid, n_out_valid;
    logic [OFF_W-1:0] r_out_offset;
    logic [VAL_W-1:0] r_out_value;
    logic             r_block_last;

    logic w_accept, w_load, w_x_end, w_y_end, w_z_end, w_last, w_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width      <= 11'd1;
            r_in_height     <= 11'd1;
            r_in_depth      <= 7'd1;
            r_channel_count <= 11'd1;
            r_scale_x       <= 3'd1;
            r_scale_y       <= 3'd1;
            r_scale_z       <= 3'd1;
            r_fill_mode     <= FILL_REPLICATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IN_WIDTH:      r_in_width      <= i_cfg_data;
                REG_IN_HEIGHT:     r_in_height     <= i_cfg_data;
                REG_IN_DEPTH:      r_in_depth      <= i_cfg_data[6:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                REG_SCALE_X:       r_scale_x       <= i_cfg_data[2:0];
                REG_SCALE_Y:       r_scale_y       <= i_cfg_data[2:0];
                REG_SCALE_Z:       r_scale_z       <= i_cfg_data[2:0];
                REG_FILL_MODE:     r_fill_mode     <= i_cfg_data[0];
            endcase
        end
    end

    // Zero acts as one, oversized values clip at the maximum.
    assign w_w  = DIM_W'(f_eff(16'(r_in_width), 16'(MAX_PLANE_DIM)));
    assign w_h  = DIM_W'(f_eff(16'(r_in_height), 16'(MAX_PLANE_DIM)));
    assign w_d  = DD_W'(f_eff(16'(r_in_depth), 16'(MAX_DEPTH)));
    assign w_c  = CH_W'(f_eff(16'(r_channel_count), 16'(MAX_CHANNELS)));
    assign w_sx = SC_W'(f_eff(16'(r_scale_x), 16'(MAX_SCALE)));
    assign w_sy = SC_W'(f_eff(16'(r_scale_y), 16'(MAX_SCALE)));
    assign w_sz = SC_W'(f_eff(16'(r_scale_z), 16'(MAX_SCALE)));

    nus_pos #(
        .MAX_PLANE_DIM (MAX_PLANE_DIM),
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_load && w_last),
        .i_width    (w_w),
        .i_height   (w_h),
        .i_depth    (w_d),
        .i_channels (w_c),
        .o_pos_x    (w_pos_x),
        .o_pos_y    (w_pos_y),
        .o_pos_z    (w_pos_z),
        .o_pos_c    (w_pos_c)
    );

    nus_mul #(
        .A_W (OFF_W),
        .B_W (MB_W),
        .P_W (OFF_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Operands for each step; a product is written back one step after it is issued.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_step)
            ST_OUT_X: begin
                w_mul_a = OFF_W'(w_w);
                w_mul_b = MB_W'(w_sx);
            end
            ST_OUT_Y: begin
                w_mul_a = OFF_W'(w_h);
                w_mul_b = MB_W'(w_sy);
            end
            ST_OUT_Z: begin
                w_mul_a = OFF_W'(w_d);
                w_mul_b = MB_W'(w_sz);
            end
            ST_STRIDE: begin
                w_mul_a = OFF_W'(r_out_y);
                w_mul_b = MB_W'(r_out_x);
            end
            ST_Z0: begin
                w_mul_a = OFF_W'(w_pos_z);
                w_mul_b = MB_W'(w_sz);
            end
            ST_Y0: begin
                w_mul_a = OFF_W'(w_pos_y);
                w_mul_b = MB_W'(w_sy);
            end
            ST_X0: begin
                w_mul_a = OFF_W'(w_pos_x);
                w_mul_b = MB_W'(w_sx);
            end
            ST_CH: begin
                w_mul_a = OFF_W'(w_pos_c);
                w_mul_b = MB_W'(r_out_z);
            end
            ST_MUL_Y: begin
                w_mul_a = r_acc;
                w_mul_b = MB_W'(r_out_y);
            end
            ST_MUL_X: begin
                w_mul_a = r_acc;
                w_mul_b = MB_W'(r_out_x);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign w_x_end  = !(((SC_W+1)'(r_ox) + (SC_W+1)'(1)) < (SC_W+1)'(w_sx));
    assign w_y_end  = !(((SC_W+1)'(r_oy) + (SC_W+1)'(1)) < (SC_W+1)'(w_sy));
    assign w_z_end  = !(((SC_W+1)'(r_oz) + (SC_W+1)'(1)) < (SC_W+1)'(w_sz));
    assign w_last   = w_x_end && w_y_end && w_z_end;
    assign w_corner = (r_ox == '0) && (r_oy == '0) && (r_oz == '0);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                n_step = ST_OUT_X;
                if (w_accept) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_step = r_step + 4'd1;
                if (r_step == ST_BASE) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_OUT_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath: setup write-backs, then the walk across the block one write per beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_sample_value;
        end
        if (r_state == S_SETUP) begin
            unique case (r_step)
                ST_OUT_Y:  r_out_x  <= w_prod[OX_W-1:0];
                ST_OUT_Z:  r_out_y  <= w_prod[OX_W-1:0];
                ST_STRIDE: r_out_z  <= w_prod[OZ_W-1:0];
                ST_Z0:     r_stride <= w_prod;
                ST_Y0:     r_z0     <= w_prod[OZ_W-1:0];
                ST_X0:     r_y0     <= w_prod[OX_W-1:0];
                ST_CH:     r_x0     <= w_prod[OX_W-1:0];
                ST_ADD_Z:  r_acc    <= w_prod + OFF_W'(r_z0);
                ST_ADD_Y:  r_acc    <= w_prod + OFF_W'(r_y0);
                ST_BASE: begin
                    r_off   <= w_prod + OFF_W'(r_x0);
                    r_row   <= w_prod + OFF_W'(r_x0);
                    r_plane <= w_prod + OFF_W'(r_x0);
                    r_ox    <= '0;
                    r_oy    <= '0;
                    r_oz    <= '0;
                end
                default: begin
                end
            endcase
        end
        if (w_load) begin
            r_out_offset <= r_off;
            r_out_value  <= ((r_fill_mode == FILL_REPLICATE) || w_corner) ? r_value : '0;
            r_block_last <= w_last;
            priority if (!w_x_end) begin
                r_ox  <= r_ox + SC_W'(1);
                r_off <= r_off + OFF_W'(1);
            end else if (!w_y_end) begin
                r_ox  <= '0;
                r_oy  <= r_oy + SC_W'(1);
                r_row <= r_row + OFF_W'(r_out_x);
                r_off <= r_row + OFF_W'(r_out_x);
            end else begin
                r_ox    <= '0;
                r_oy    <= '0;
                r_oz    <= r_oz + SC_W'(1);
                r_plane <= r_plane + r_stride;
                r_row   <= r_plane + r_stride;
                r_off   <= r_plane + r_stride;
            end
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_offset = r_out_offset;
    assign o_out_value  = r_out_value;
    assign o_block_last = r_block_last;
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the 3-D nearest-neighbour upsampling scatter core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nus_pkg::*;

    localparam logic FILL_ZERO_INSERT = ~FILL_REPLICATE;
    localparam int   RANDOM_ITEMS     = 350;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_upsample_write;

    // Writable bits of each register, by register index.
    localparam logic [CFG_W-1:0] REG_MASK [8] = '{
        11'h7FF, 11'h7FF, 11'h07F, 11'h7FF, 11'h007, 11'h007, 11'h007, 11'h001
    };

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [VAL_W-1:0]     i_sample_value = '0;
    logic                 i_out_ready    = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OFF_W-1:0]     o_out_offset;
    logic [VAL_W-1:0]     o_out_value;
    logic                 o_block_last;

    nearest_upsample_scatter_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_offset   (o_out_offset),
        .o_out_value    (o_out_value),
        .o_block_last   (o_block_last)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the configuration and of the raster position counters.
    logic [CFG_W-1:0] shadow_regs [8] = '{
        11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0
    };
    logic [9:0] pos_x  = '0;
    logic [9:0] pos_y  = '0;
    logic [5:0] pos_z  = '0;
    logic [9:0] pos_ch = '0;

    t_upsample_write expected_writes [$];
    int unsigned     error_count = 0;
    bit              no_idle     = 1'b0;

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic longint unsigned eff_size(input logic [CFG_W-1:0] raw,
                                                 input int unsigned limit);
        if (raw == '0) return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    // Queues the block of writes one element produces, then steps the raster counters.
    function automatic void scatter_element(input logic [VAL_W-1:0] value);
        longint unsigned w, h, d, c, sx, sy, sz, total, k, off;
        t_upsample_write wr;
        w  = eff_size(shadow_regs[REG_IN_WIDTH], DEF_MAX_PLANE_DIM);
        h  = eff_size(shadow_regs[REG_IN_HEIGHT], DEF_MAX_PLANE_DIM);
        d  = eff_size(shadow_regs[REG_IN_DEPTH], DEF_MAX_DEPTH);
        c  = eff_size(shadow_regs[REG_CHANNEL_COUNT], DEF_MAX_CHANNELS);
        sx = eff_size(shadow_regs[REG_SCALE_X], DEF_MAX_SCALE);
        sy = eff_size(shadow_regs[REG_SCALE_Y], DEF_MAX_SCALE);
        sz = eff_size(shadow_regs[REG_SCALE_Z], DEF_MAX_SCALE);
        total = sx * sy * sz;
        k = 0;
        for (longint unsigned oz = 0; oz < sz; oz++) begin
            for (longint unsigned oy = 0; oy < sy; oy++) begin
                for (longint unsigned ox = 0; ox < sx; ox++) begin
                    off = ((longint'(pos_ch) * d * sz + longint'(pos_z) * sz + oz) * h * sy
                           + longint'(pos_y) * sy + oy) * w * sx + longint'(pos_x) * sx + ox;
                    wr.offset = off[OFF_W-1:0];
                    if (shadow_regs[REG_FILL_MODE][0] == FILL_REPLICATE ||
                        (oz == 0 && oy == 0 && ox == 0))
                        wr.value = value;
                    else
                        wr.value = '0;
                    k++;
                    wr.last = (k == total);
                    expected_writes.push_back(wr);
                end
            end
        end
        if (pos_x + 1 < w) begin
            pos_x++;
        end else begin
            pos_x = '0;
            if (pos_y + 1 < h) begin
                pos_y++;
            end else begin
                pos_y = '0;
                if (pos_z + 1 < d) begin
                    pos_z++;
                end else begin
                    pos_z = '0;
                    if (pos_ch + 1 < c) pos_ch++;
                    else pos_ch = '0;
                end
            end
        end
    endfunction

    // Leaves the write enable high; load_config lowers it once after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        shadow_regs[idx] = data & REG_MASK[idx];
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] w, h, d, c, sx, sy, sz, fill);
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_IN_DEPTH, d);
        write_reg(REG_CHANNEL_COUNT, c);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_SCALE_Z, sz);
        write_reg(REG_FILL_MODE, fill);
        i_cfg_we <= 1'b0;
    endtask

    // Valid is only lowered when a gap is drawn, so back-to-back beats never see it toggle.
    task automatic send_sample(input logic [VAL_W-1:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        scatter_element(value);
    endtask

    task automatic drain_writes();
        i_in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Output side: a fresh stall is drawn for every beat.
    initial begin
        int unsigned stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    always @(posedge i_clk) begin
        t_upsample_write want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_writes.size() == 0) begin
                report_error($sformatf("unexpected write beat, offset %0h", o_out_offset));
            end else begin
                want = expected_writes.pop_front();
                if (o_out_offset !== want.offset)
                    report_error($sformatf("offset %0h, expected %0h",
                                           o_out_offset, want.offset));
                if (o_out_value !== want.value)
                    report_error($sformatf("value %0h at offset %0h, expected %0h",
                                           o_out_value, want.offset, want.value));
                if (o_block_last !== want.last)
                    report_error($sformatf("block_last %b at offset %0h, expected %b",
                                           o_block_last, want.offset, want.last));
            end
        end
    end

    task automatic test_reset_defaults();
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        drain_writes();
    endtask

    // Zero registers act as one; oversized ones clamp, and bits above each width are dropped.
    task automatic test_zero_and_oversized();
        load_config('0, '0, '0, '0, '0, '0, '0, '0);
        send_sample(32'h1234_5678);
        drain_writes();
        load_config(11'h7FF, 11'd1500, 11'h7C1, 11'h7FF, 11'd7, 11'h7FD, 11'd6, 11'h7FE);
        send_sample(32'hDEAD_BEEF);
        drain_writes();
        load_config(11'h7FF, 11'd1500, 11'h7C1, 11'h7FF, 11'd7, 11'h7FD, 11'd6,
                    {10'h0, FILL_ZERO_INSERT});
        send_sample(32'hCAFE_F00D);
        drain_writes();
    endtask

    task automatic test_fill_modes();
        load_config(11'd3, 11'd2, 11'd2, 11'd2, 11'd2, 11'd3, 11'd1, {10'h0, FILL_REPLICATE});
        send_sample(32'hAAAA_AAAA);
        send_sample(32'h5555_5555);
        drain_writes();
        load_config(11'd3, 11'd2, 11'd2, 11'd2, 11'd2, 11'd3, 11'd1,
                    {10'h0, FILL_ZERO_INSERT});
        send_sample(32'h5555_5555);
        send_sample(32'hAAAA_AAAA);
        drain_writes();
    endtask

    // Shrinking the width leaves x beyond the new size; it is used once and then wraps.
    task automatic test_mid_sample_shrink();
        load_config(11'd8, 11'd2, 11'd1, 11'd1, 11'd1, 11'd2, 11'd1, {10'h0, FILL_REPLICATE});
        repeat (5) send_sample($urandom);
        drain_writes();
        load_config(11'd3, 11'd2, 11'd1, 11'd1, 11'd1, 11'd2, 11'd1, {10'h0, FILL_REPLICATE});
        repeat (3) send_sample($urandom);
        drain_writes();
    endtask

    // Walk the channel counter forward cheaply, then switch to full sizes for wide offsets.
    task automatic test_deep_offset();
        load_config(11'd1, 11'd1, 11'd1, 11'd1024, 11'd1, 11'd1, 11'd1, {10'h0, FILL_REPLICATE});
        repeat (8) send_sample($urandom);
        drain_writes();
        load_config(11'd1024, 11'd1024, 11'd64, 11'd1024, 11'd4, 11'd4, 11'd4,
                    {10'h0, FILL_ZERO_INSERT});
        repeat (2) send_sample($urandom);
        drain_writes();
    endtask

    function automatic logic [CFG_W-1:0] pick_size(input logic [CFG_W-1:0] field_max);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'($urandom_range(0, field_max));
        if (r == 2) return field_max;
        return CFG_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [CFG_W-1:0] pick_scale();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return CFG_W'($urandom_range(0, 2047));
        if (r == 1) return 11'd4;
        return CFG_W'($urandom_range(1, 2));
    endfunction

    task automatic test_random_phases();
        int unsigned sent, n;
        logic [VAL_W-1:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            load_config(pick_size(11'h7FF), pick_size(11'h7FF), pick_size(11'h7F),
                        pick_size(11'h7FF), pick_scale(), pick_scale(), pick_scale(),
                        CFG_W'($urandom_range(0, 2047)));
            n = $urandom_range(4, 24);
            repeat (n) begin
                case ($urandom_range(0, 15))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom;
                endcase
                send_sample(value);
            end
            sent += n;
            drain_writes();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_and_oversized();
        test_fill_modes();
        test_mid_sample_shrink();
        test_deep_offset();
        test_random_phases();
        drain_writes();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d writes outstanding", expected_writes.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: nearest_upsample_scatter_core.f
hdl/nus_pkg.sv
hdl/nus_mul.sv
hdl/nus_pos.sv
hdl/nearest_upsample_scatter_core.sv
tb/tb_top.sv
